[design/rgb_linear_crossfade_top_macros.svh]
// assertion macros used by the asserting top-level file
`ifndef RGB_LINEAR_CROSSFADE_TOP_MACROS_SVH
`define RGB_LINEAR_CROSSFADE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define RLC_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

`define RLC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define RLC_ASSERT_IMP(name, clk, rstn, ante, cons)

`define RLC_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

[design/rlc_pkg.sv]
package rlc_pkg;

    localparam int NUM_CH  = 3;
    localparam int PCT_W   = 7;
    localparam int LEVEL_W = 8;
    localparam int FADE_W  = 12;
    localparam int CNT_W   = 4;

    localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [FADE_W-1:0]  FADE_RESET = 12'd1020;

    // x / 100 as (x * 5243) >> 19, exact for x up to 25500
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // one quotient bit per divide cycle
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FADE_W - 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic capture;
        logic tick;
        logic scale;
        logic div_step;
        logic out_load;
    } rlc_cmd_t;

    function automatic logic [LEVEL_W-1:0] pct_to_level(input logic [PCT_W-1:0] p);
        logic [PCT_W-1:0] v;
        logic [14:0]      x;
        logic [27:0]      prod;
        v    = (p > PCT_MAX) ? PCT_MAX : p;
        x    = {v, 8'b0} - 15'(v);
        prod = 28'(x) * 28'(RECIP_100);
        return prod[RECIP_SHIFT +: LEVEL_W];
    endfunction

endpackage

[design/rgb_linear_crossfade_top.sv]
// flow: a tick word goes from accept to ST_RESPOND, a load word through ST_SCALE and ST_DIVIDE;
//   the result is registered in ST_RESPOND once the output is free, and a new word is taken
//   only in ST_IDLE; loads use the bit-serial divider (one quotient bit per cycle, three channels at once)
// reset: aresetn is synchronous, active low; levels go to 0, no fade is running,
//   fade_length returns to 1020 and no result word is pending
`include "rgb_linear_crossfade_top_macros.svh"

module rgb_linear_crossfade_top
    import rlc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [PCT_W-1:0]   s_target_red_pct,
    input  logic [PCT_W-1:0]   s_target_green_pct,
    input  logic [PCT_W-1:0]   s_target_blue_pct,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_red_out,
    output logic [LEVEL_W-1:0] m_green_out,
    output logic [LEVEL_W-1:0] m_blue_out,
    output logic               m_fade_active,
    output logic               m_fade_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FADE_W-1:0]  cfg_fade_length
);

    rlc_cmd_t cmd;

    rlc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .cmd      (cmd)
    );

    rlc_dpath u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .s_target_red_pct   (s_target_red_pct),
        .s_target_green_pct (s_target_green_pct),
        .s_target_blue_pct  (s_target_blue_pct),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_fade_length    (cfg_fade_length),
        .m_red_out          (m_red_out),
        .m_green_out        (m_green_out),
        .m_blue_out         (m_blue_out),
        .m_fade_active      (m_fade_active),
        .m_fade_done        (m_fade_done)
    );

    // one word in flight at a time
    `RLC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a result word only follows work on an accepted word
    `RLC_ASSERT_IMP(a_result_after_work, aclk, aresetn, $rose(m_valid), !$past(s_ready))

    // the completing tick ends the fade
    `RLC_ASSERT_IMP(a_done_not_active, aclk, aresetn, m_valid && m_fade_done, !m_fade_active)

endmodule

[design/rlc_ctrl.sv]
module rlc_ctrl
    import rlc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_opcode,
    output logic     s_ready,
    input  logic     m_ready,
    output logic     m_valid,
    output rlc_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIVIDE,
        ST_RESPOND
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;
    logic             accept;
    logic             out_free;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.capture  = accept && (s_opcode == OP_LOAD);
        cmd.tick     = accept && (s_opcode == OP_TICK);
        cmd.scale    = (state_reg == ST_SCALE);
        cmd.div_step = (state_reg == ST_DIVIDE);
        cmd.out_load = (state_reg == ST_RESPOND) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_RESPOND) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        // a tick is applied in the accept cycle itself
                        state_reg <= (s_opcode == OP_LOAD) ? ST_SCALE : ST_RESPOND;
                    end
                end
                ST_SCALE: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= ST_RESPOND;
                    end
                end
                ST_RESPOND: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[design/rlc_dpath.sv]
module rlc_dpath
    import rlc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  rlc_cmd_t           cmd,
    input  logic [PCT_W-1:0]   s_target_red_pct,
    input  logic [PCT_W-1:0]   s_target_green_pct,
    input  logic [PCT_W-1:0]   s_target_blue_pct,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FADE_W-1:0]  cfg_fade_length,
    output logic [LEVEL_W-1:0] m_red_out,
    output logic [LEVEL_W-1:0] m_green_out,
    output logic [LEVEL_W-1:0] m_blue_out,
    output logic               m_fade_active,
    output logic               m_fade_done
);

    logic [PCT_W-1:0]   pct_in     [NUM_CH];
    logic [PCT_W-1:0]   pct_reg    [NUM_CH];
    logic [LEVEL_W-1:0] level_reg  [NUM_CH];
    logic [FADE_W-1:0]  quot_reg   [NUM_CH];
    logic [LEVEL_W-1:0] rem_reg    [NUM_CH];
    logic [LEVEL_W-1:0] divisor_reg[NUM_CH];
    logic               neg_reg    [NUM_CH];
    logic               zero_reg   [NUM_CH];
    logic [FADE_W-1:0]  phase_reg  [NUM_CH];

    logic [FADE_W-1:0]  tick_index_reg;
    logic [FADE_W-1:0]  fade_length_reg;
    logic               running_reg;
    logic               done_reg;

    logic [LEVEL_W:0]   gap        [NUM_CH];
    logic [LEVEL_W-1:0] gap_abs    [NUM_CH];
    logic [LEVEL_W:0]   rem_sh     [NUM_CH];
    logic               quot_bit   [NUM_CH];
    logic [LEVEL_W-1:0] rem_next   [NUM_CH];
    logic [LEVEL_W-1:0] level_next [NUM_CH];
    logic [FADE_W-1:0]  phase_inc  [NUM_CH];
    logic [FADE_W-1:0]  phase_next [NUM_CH];
    logic               hit        [NUM_CH];
    logic               fade_end;

    assign cfg_ready = 1'b1;
    assign fade_end  = (tick_index_reg >= fade_length_reg);

    assign pct_in[0] = s_target_red_pct;
    assign pct_in[1] = s_target_green_pct;
    assign pct_in[2] = s_target_blue_pct;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            // signed gap target - level
            gap[c]     = {1'b0, pct_to_level(pct_reg[c])} - {1'b0, level_reg[c]};
            gap_abs[c] = gap[c][LEVEL_W] ? LEVEL_W'(-gap[c]) : gap[c][LEVEL_W-1:0];

            // restoring division, one quotient bit per cycle
            rem_sh[c]   = {rem_reg[c], quot_reg[c][FADE_W-1]};
            quot_bit[c] = (rem_sh[c] >= {1'b0, divisor_reg[c]});
            rem_next[c] = quot_bit[c] ? LEVEL_W'(rem_sh[c] - {1'b0, divisor_reg[c]})
                                      : rem_sh[c][LEVEL_W-1:0];

            // phase tracks tick_index mod |step|
            hit[c] = !zero_reg[c] && (quot_reg[c] != '0) && (phase_reg[c] == '0);
            if (!hit[c]) begin
                level_next[c] = level_reg[c];
            end else if (neg_reg[c]) begin
                level_next[c] = (level_reg[c] == '0) ? '0 : level_reg[c] - 1'b1;
            end else begin
                level_next[c] = (level_reg[c] == LEVEL_MAX) ? LEVEL_MAX
                                                             : level_reg[c] + 1'b1;
            end
            phase_inc[c]  = phase_reg[c] + 1'b1;
            phase_next[c] = (phase_inc[c] == quot_reg[c]) ? '0 : phase_inc[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_length_reg <= FADE_RESET;
            tick_index_reg  <= '0;
            running_reg     <= 1'b0;
            done_reg        <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                level_reg[c] <= '0;
                zero_reg[c]  <= 1'b1;
            end
        end else begin
            if (cfg_valid) begin
                fade_length_reg <= cfg_fade_length;
            end
            if (cmd.scale) begin
                tick_index_reg <= '0;
                running_reg    <= 1'b1;
                done_reg       <= 1'b0;
                for (int c = 0; c < NUM_CH; c++) begin
                    zero_reg[c] <= (gap[c] == '0);
                end
            end
            if (cmd.tick) begin
                done_reg <= running_reg && fade_end;
                if (running_reg) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        level_reg[c] <= level_next[c];
                    end
                    if (fade_end) begin
                        running_reg <= 1'b0;
                    end else begin
                        tick_index_reg <= tick_index_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (cmd.capture) begin
                pct_reg[c] <= pct_in[c];
            end
            if (cmd.scale) begin
                divisor_reg[c] <= gap_abs[c];
                neg_reg[c]     <= gap[c][LEVEL_W];
                rem_reg[c]     <= '0;
                quot_reg[c]    <= fade_length_reg;
                phase_reg[c]   <= '0;
            end
            if (cmd.div_step) begin
                rem_reg[c]  <= rem_next[c];
                quot_reg[c] <= {quot_reg[c][FADE_W-2:0], quot_bit[c]};
            end
            if (cmd.tick && running_reg) begin
                phase_reg[c] <= phase_next[c];
            end
        end
        if (cmd.out_load) begin
            m_red_out     <= level_reg[0];
            m_green_out   <= level_reg[1];
            m_blue_out    <= level_reg[2];
            m_fade_active <= running_reg;
            m_fade_done   <= done_reg;
        end
    end

endmodule
